// File: sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_WIDTH     = 16;
   localparam int SQRT_FRAC_BITS = 16;
   localparam int ROOT_OUT_W     = 17;
   localparam int ROOT_MAX       = 65535;
   localparam int ROOT_MIN       = -65536;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_REAL    = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [ROOT_OUT_W-1:0] root_type;

endpackage

// File: sv/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs request and response channels
// valid/ready streams carrying coefficients and roots
// ----------------------------------------------------------------------------
interface qrs_req_if;
   logic               valid;
   logic               ready;
   qrs_pkg::coef_type  coef_a;
   qrs_pkg::coef_type  coef_b;
   qrs_pkg::coef_type  coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_rsp_if;
   logic                valid;
   logic                ready;
   qrs_pkg::status_type status;
   qrs_pkg::root_type   root_plus;
   qrs_pkg::root_type   root_minus;

   modport source (output valid, output status, output root_plus, output root_minus,
                   input ready);
   modport sink   (input valid, input status, input root_plus, input root_minus,
                   output ready);
endinterface

// File: sv/quadratic_root_solver_top.sv
// throughput: one transaction per cycle unless the response register is held,
//   set by a 17-stage square root pipeline and two 17-stage restoring dividers,
//   one quotient bit per stage
// the whole pipeline stalls together while the response register is held
// reset clears all stage valid bits; no clearing pass is needed
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// real roots of a*x^2 + b*x + c by exact discriminant, bit-serial root and divide
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
   input  logic       clock,
   input  logic       reset,
   qrs_req_if.sink    req_ch,
   qrs_rsp_if.source  rsp_ch
);

   localparam int CW     = qrs_pkg::COEF_WIDTH;
   localparam int PROD_W = 2 * CW;
   localparam int ROOT_W = CW + 1;
   localparam int DISC_W = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int NUM_W  = CW + 1;
   localparam int DEN_W  = CW + 1;
   localparam int TW     = CW + 3;
   localparam int OW     = qrs_pkg::ROOT_OUT_W;

   typedef struct packed {
      logic                valid;
      qrs_pkg::status_type status;
      logic                na;
      logic                nb;
      logic [CW-1:0]       ma;
      logic [CW-1:0]       mb;
      logic [DISC_W-1:0]   dsh;
      logic [REM_W-1:0]    rem;
      logic [ROOT_W-1:0]   q;
   } sqrt_stage_type;

   typedef struct packed {
      logic                valid;
      qrs_pkg::status_type status;
      logic                sp;
      logic                sm;
      logic [NUM_W-1:0]    nump;
      logic [NUM_W-1:0]    numm;
      logic [DEN_W-1:0]    remp;
      logic [DEN_W-1:0]    remm;
      logic [NUM_W-1:0]    qp;
      logic [NUM_W-1:0]    qm;
      logic [DEN_W-1:0]    dv;
   } div_stage_type;

   logic                 en;

   logic                 v1_ff, zero1_ff, na1_ff, nb1_ff, nc1_ff;
   logic [CW-1:0]        ma1_ff, mb1_ff, mc1_ff;
   logic                 v2_ff, zero2_ff, na2_ff, nb2_ff, same2_ff;
   logic [CW-1:0]        ma2_ff, mb2_ff;
   logic [PROD_W-1:0]    bsq2_ff, p2_ff;

   sqrt_stage_type       sq_ff [ROOT_W+1];
   sqrt_stage_type       sq_in [ROOT_W+1];
   div_stage_type        dv_ff [NUM_W+1];
   div_stage_type        dv_in [NUM_W+1];

   logic                 rsp_valid_ff;
   qrs_pkg::status_type  status_ff;
   qrs_pkg::root_type    plus_ff, minus_ff;
   qrs_pkg::status_type  status_in;
   qrs_pkg::root_type    plus_in, minus_in;

   logic                 na_in, nb_in, nc_in;
   logic [CW-1:0]        ma_in, mb_in, mc_in;

   function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
      return v[CW-1] ? (~v + CW'(1)) : v;
   endfunction

   function automatic qrs_pkg::root_type sat_root(input logic sgn, input logic [NUM_W-1:0] m);
      logic signed [NUM_W+1:0] v;
      v = sgn ? -$signed({2'b00, m}) : $signed({2'b00, m});
      if (v > $signed((NUM_W+2)'(qrs_pkg::ROOT_MAX)))
         return OW'(qrs_pkg::ROOT_MAX);
      else if (v < $signed((NUM_W+2)'(qrs_pkg::ROOT_MIN)))
         return OW'(qrs_pkg::ROOT_MIN);
      else
         return OW'(v);
   endfunction

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.root_plus  = plus_ff;
   assign rsp_ch.root_minus = minus_ff;

   assign na_in = req_ch.coef_a[CW-1];
   assign nb_in = req_ch.coef_b[CW-1];
   assign nc_in = req_ch.coef_c[CW-1];
   assign ma_in = mag_of(req_ch.coef_a);
   assign mb_in = mag_of(req_ch.coef_b);
   assign mc_in = mag_of(req_ch.coef_c);

   // discriminant stage and square root steps
   always_comb begin
      logic [DISC_W-1:0]  bsq, fac;
      logic [REM_W+1:0]   t, trial;
      bsq = DISC_W'(bsq2_ff);
      fac = {p2_ff, 2'b00};
      sq_in[0]        = '0;
      sq_in[0].valid  = v2_ff;
      sq_in[0].na     = na2_ff;
      sq_in[0].nb     = nb2_ff;
      sq_in[0].ma     = ma2_ff;
      sq_in[0].mb     = mb2_ff;
      sq_in[0].status = qrs_pkg::STATUS_OK;
      if (same2_ff) begin
         sq_in[0].dsh = bsq - fac;
         if (bsq < fac)
            sq_in[0].status = qrs_pkg::STATUS_NO_REAL;
      end else begin
         sq_in[0].dsh = bsq + fac;
      end
      if (zero2_ff)
         sq_in[0].status = qrs_pkg::STATUS_DEGENERATE;
      for (int k = 0; k < ROOT_W; k++) begin
         sq_in[k+1] = sq_ff[k];
         t     = {sq_ff[k].rem, sq_ff[k].dsh[DISC_W-1 -: 2]};
         trial = (REM_W+2)'({sq_ff[k].q, 2'b01});
         sq_in[k+1].dsh = {sq_ff[k].dsh[DISC_W-3:0], 2'b00};
         if (t >= trial) begin
            t = t - trial;
            sq_in[k+1].q = {sq_ff[k].q[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k+1].q = {sq_ff[k].q[ROOT_W-2:0], 1'b0};
         end
         sq_in[k+1].rem = t[REM_W-1:0];
      end
   end

   // numerator adjust and divider steps
   always_comb begin
      sqrt_stage_type       s;
      logic [ROOT_W:0]      lim;
      logic                 frac;
      logic signed [TW-1:0] bs, tp, tm;
      logic [TW-1:0]        ap, am;
      logic [DEN_W:0]       t;
      s    = sq_ff[ROOT_W];
      lim  = (ROOT_W+1)'({s.q, 1'b0} >> qrs_pkg::SQRT_FRAC_BITS);
      frac = s.rem > REM_W'(lim);
      bs   = s.nb ? -$signed(TW'(s.mb)) : $signed(TW'(s.mb));
      tp   = -bs + $signed(TW'(s.q));
      if (tp < 0 && frac)
         tp = tp + TW'(1);
      tm   = -bs - $signed(TW'(s.q));
      if (tm > 0 && frac)
         tm = tm - TW'(1);
      ap = tp[TW-1] ? TW'(-tp) : TW'(tp);
      am = tm[TW-1] ? TW'(-tm) : TW'(tm);
      dv_in[0]        = '0;
      dv_in[0].valid  = s.valid;
      dv_in[0].status = s.status;
      dv_in[0].sp     = tp[TW-1] ^ s.na;
      dv_in[0].sm     = tm[TW-1] ^ s.na;
      dv_in[0].nump   = ap[NUM_W-1:0];
      dv_in[0].numm   = am[NUM_W-1:0];
      dv_in[0].dv     = {s.ma, 1'b0};
      for (int k = 0; k < NUM_W; k++) begin
         dv_in[k+1] = dv_ff[k];
         dv_in[k+1].nump = {dv_ff[k].nump[NUM_W-2:0], 1'b0};
         dv_in[k+1].numm = {dv_ff[k].numm[NUM_W-2:0], 1'b0};
         t = {dv_ff[k].remp, dv_ff[k].nump[NUM_W-1]};
         if (t >= {1'b0, dv_ff[k].dv}) begin
            t = t - {1'b0, dv_ff[k].dv};
            dv_in[k+1].qp = {dv_ff[k].qp[NUM_W-2:0], 1'b1};
         end else begin
            dv_in[k+1].qp = {dv_ff[k].qp[NUM_W-2:0], 1'b0};
         end
         dv_in[k+1].remp = t[DEN_W-1:0];
         t = {dv_ff[k].remm, dv_ff[k].numm[NUM_W-1]};
         if (t >= {1'b0, dv_ff[k].dv}) begin
            t = t - {1'b0, dv_ff[k].dv};
            dv_in[k+1].qm = {dv_ff[k].qm[NUM_W-2:0], 1'b1};
         end else begin
            dv_in[k+1].qm = {dv_ff[k].qm[NUM_W-2:0], 1'b0};
         end
         dv_in[k+1].remm = t[DEN_W-1:0];
      end
   end

   always_comb begin
      status_in = dv_ff[NUM_W].status;
      if (dv_ff[NUM_W].status == qrs_pkg::STATUS_OK) begin
         plus_in  = sat_root(dv_ff[NUM_W].sp, dv_ff[NUM_W].qp);
         minus_in = sat_root(dv_ff[NUM_W].sm, dv_ff[NUM_W].qm);
      end else begin
         plus_in  = '0;
         minus_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++)
            sq_ff[k].valid <= 1'b0;
         for (int k = 0; k <= NUM_W; k++)
            dv_ff[k].valid <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_ch.valid;
         zero1_ff <= (ma_in == '0);
         na1_ff   <= na_in;
         nb1_ff   <= nb_in;
         nc1_ff   <= nc_in;
         ma1_ff   <= ma_in;
         mb1_ff   <= mb_in;
         mc1_ff   <= mc_in;

         v2_ff    <= v1_ff;
         zero2_ff <= zero1_ff;
         na2_ff   <= na1_ff;
         nb2_ff   <= nb1_ff;
         same2_ff <= (mc1_ff != '0) && (na1_ff == nc1_ff);
         ma2_ff   <= ma1_ff;
         mb2_ff   <= mb1_ff;
         bsq2_ff  <= mb1_ff * mb1_ff;
         p2_ff    <= ma1_ff * mc1_ff;

         for (int k = 0; k <= ROOT_W; k++)
            sq_ff[k] <= sq_in[k];
         for (int k = 0; k <= NUM_W; k++)
            dv_ff[k] <= dv_in[k];

         rsp_valid_ff <= dv_ff[NUM_W].valid;
         status_ff    <= status_in;
         plus_ff      <= plus_in;
         minus_ff     <= minus_in;
      end
   end

endmodule

// File: sv/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks of the quadratic root solver, bound to the top level
// ----------------------------------------------------------------------------
module qrs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          status,
   input qrs_pkg::root_type   root_plus,
   input qrs_pkg::root_type   root_minus
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output register");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= 2'(qrs_pkg::STATUS_DEGENERATE))
      else $error("undefined status code");

   a_zero_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != qrs_pkg::STATUS_OK |-> root_plus == '0 && root_minus == '0)
      else $error("nonzero roots with failing status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .status     (rsp_ch.status),
   .root_plus  (rsp_ch.root_plus),
   .root_minus (rsp_ch.root_minus)
);

// File: tb/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top
// coefficient transactions with random gaps on both channels
// in-order root predictor checks status and both roots of every response
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;

   typedef struct {
      qrs_pkg::coef_type a;
      qrs_pkg::coef_type b;
      qrs_pkg::coef_type c;
      bit                drain;
   } coef_set_type;

   typedef struct {
      qrs_pkg::status_type status;
      qrs_pkg::root_type   plus;
      qrs_pkg::root_type   minus;
   } roots_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qrs_req_if req_ch ();
   qrs_rsp_if rsp_ch ();

   quadratic_root_solver_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   coef_set_type pending_sets[$];
   roots_type    expected_roots[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        stim_done   = 1'b0;
   bit        req_taken   = 1'b0;
   bit        rsp_taken   = 1'b0;
   int        req_gap     = 0;
   int        rsp_gap     = 0;
   bit        calm_mode   = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic roots_type solve_roots(qrs_pkg::coef_type a, qrs_pkg::coef_type b,
                                             qrs_pkg::coef_type c);
      roots_type  r;
      longint     av, bv, cv, disc, root, t, e, lim, den, tp, tm, qp, qm;
      bit         frac;
      av = a;
      bv = b;
      cv = c;
      r.status = qrs_pkg::STATUS_OK;
      r.plus   = '0;
      r.minus  = '0;
      if (av == 0) begin
         r.status = qrs_pkg::STATUS_DEGENERATE;
         return r;
      end
      disc = bv * bv - 4 * av * cv;
      if (disc < 0) begin
         r.status = qrs_pkg::STATUS_NO_REAL;
         return r;
      end
      root = 0;
      for (int i = 33; i >= 0; i--) begin
         t = root | (64'sd1 << i);
         if (t <= 64'sd3037000499 && t * t <= disc)
            root = t;
      end
      e    = disc - root * root;
      lim  = (2 * root) >>> qrs_pkg::SQRT_FRAC_BITS;
      frac = e > lim;
      den  = 2 * av;
      tp   = -bv + root;
      if (tp < 0 && frac) tp = tp + 1;
      tm   = -bv - root;
      if (tm > 0 && frac) tm = tm - 1;
      qp   = tp / den;
      qm   = tm / den;
      if (qp > qrs_pkg::ROOT_MAX) qp = qrs_pkg::ROOT_MAX;
      if (qp < qrs_pkg::ROOT_MIN) qp = qrs_pkg::ROOT_MIN;
      if (qm > qrs_pkg::ROOT_MAX) qm = qrs_pkg::ROOT_MAX;
      if (qm < qrs_pkg::ROOT_MIN) qm = qrs_pkg::ROOT_MIN;
      r.plus  = qrs_pkg::root_type'(qp);
      r.minus = qrs_pkg::root_type'(qm);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   task automatic add_set(int a, int b, int c, bit drain = 1'b0);
      coef_set_type s;
      s.a     = qrs_pkg::coef_type'(a);
      s.b     = qrs_pkg::coef_type'(b);
      s.c     = qrs_pkg::coef_type'(c);
      s.drain = drain;
      pending_sets.push_back(s);
   endtask

   function automatic int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.coef_a <= '0;
         req_ch.coef_b <= '0;
         req_ch.coef_c <= '0;
         rsp_ch.ready  <= 1'b0;
      end else begin
         if (req_ch.valid && !req_taken) begin
            // hold the transaction
         end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap--;
         end else if (pending_sets.size() > 0 &&
                      !(pending_sets[0].drain && expected_roots.size() > 0)) begin
            req_ch.valid  <= 1'b1;
            req_ch.coef_a <= pending_sets[0].a;
            req_ch.coef_b <= pending_sets[0].b;
            req_ch.coef_c <= pending_sets[0].c;
            pending_sets.pop_front();
            req_gap = calm_mode ? 0 : $urandom_range(0, 3);
         end else begin
            req_ch.valid <= 1'b0;
         end

         if (rsp_taken || !rsp_ch.ready) begin
            if (rsp_taken)
               rsp_gap = calm_mode ? 0 : $urandom_range(0, 3);
            if (rsp_gap > 0) begin
               rsp_ch.ready <= 1'b0;
               rsp_gap--;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      roots_type want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      rsp_taken <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         cycle_count++;
         if (req_ch.valid && req_ch.ready) begin
            expected_roots.push_back(solve_roots(req_ch.coef_a, req_ch.coef_b,
                                                 req_ch.coef_c));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (rsp_ch.root_plus !== want.plus)
                  report_mismatch("root_plus", rsp_ch.root_plus, want.plus);
               if (rsp_ch.root_minus !== want.minus)
                  report_mismatch("root_minus", rsp_ch.root_minus, want.minus);
            end
         end
         if (cycle_count > 200000) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int a, p, q, kind;
      add_set(0, 0, 0);
      add_set(0, 1234, -77);
      add_set(1, 2, 1);
      add_set(1, 0, 1);
      add_set(1, -3, 2);
      add_set(-1, 5, 6);
      add_set(32767, 32767, 32767);
      add_set(-32768, -32768, -32768);
      add_set(-32768, 32767, 32767);
      add_set(32767, -32768, -32768);
      add_set(1, -32768, -32768);
      add_set(-1, 32767, 32767);
      add_set(1, 32767, 0);
      add_set(-1, -32768, 0);
      add_set(4, 4, 1);
      add_set(-32768, 0, 32767);
      add_set(3, 7, -11);
      add_set(2, 0, -3);
      add_set(-5, 1, 1);
      add_set(32767, 0, 0);
      add_set(1, 1, -1, 1'b1);
      for (int i = 0; i < 1000; i++) begin
         kind = $urandom_range(0, 3);
         if (kind == 0) begin
            add_set($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768, i == 500);
         end else if (kind == 1) begin
            add_set($urandom_range(0, 40) - 20, $urandom_range(0, 400) - 200,
                    $urandom_range(0, 400) - 200, i == 500);
         end else begin
            a = $urandom_range(1, 30) * ($urandom_range(0, 1) ? 1 : -1);
            p = $urandom_range(0, 200) - 100;
            q = $urandom_range(0, 200) - 100;
            add_set(a, clip16(-a * (p + q)), clip16(longint'(a) * p * q), i == 500);
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) begin
         wait (pending_sets.size() < 1022 - i * 120);
         @(negedge clock);
         calm_mode = (i % 3 == 2);
      end
      wait (pending_sets.size() == 0 && !(req_ch.valid && !req_taken));
      wait (expected_roots.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/quadratic_root_solver_top.sv
sv/qrs_checker.sv
tb/tb_quadratic_root_solver_top.sv
